### design/multi_click_counter_unit_assert.svh
// ----------------------------------------------------------------------------
// multi_click_counter_unit assertion macros
// Clocked implication checks with active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef MULTI_CLICK_COUNTER_UNIT_ASSERT_SVH
`define MULTI_CLICK_COUNTER_UNIT_ASSERT_SVH

// same-cycle implication
`define MCC_ASSERT_SAME(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("multi_click_counter_unit check failed");

// next-cycle implication
`define MCC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("multi_click_counter_unit check failed");

`endif

### design/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg
// Types and constants shared by the multi-click counter files.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int COUNT_W     = 8;
    localparam int TIMER_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTARY_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT        = 8'd1;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd50;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'hFF;

    typedef struct packed {
        logic               tick;
        logic               sample_update;
        logic               reinitialize;
        logic               level_high;
        logic               host_inject;
        logic [COUNT_W-1:0] host_clicks;
    } t_in_item;

    typedef struct packed {
        logic               momentary_mode;
        logic [TIMER_W-1:0] timeout;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] click_count;
    } t_result;

    typedef struct packed {
        logic fire;
        logic advance;
    } t_stage_ctl;

endpackage

`default_nettype wire

### design/mcc_if.sv
// ----------------------------------------------------------------------------
// mcc_if
// Valid/ready channel interfaces: input requests, results, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcc_in_if import mcc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               tick;
    logic               sample_update;
    logic               reinitialize;
    logic               level_high;
    logic               host_inject;
    logic [COUNT_W-1:0] host_clicks;

    modport source (output valid, output tick, output sample_update, output reinitialize,
                    output level_high, output host_inject, output host_clicks,
                    input ready);
    modport sink   (input valid, input tick, input sample_update, input reinitialize,
                    input level_high, input host_inject, input host_clicks,
                    output ready);
endinterface

interface mcc_out_if import mcc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] click_count;

    modport source (output valid, output click_count, input ready);
    modport sink   (input valid, input click_count, output ready);
endinterface

interface mcc_cfg_if import mcc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/multi_click_counter_unit.sv
// ----------------------------------------------------------------------------
// multi_click_counter_unit
// Counts clicks of a channel level and reports each finished burst.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : one request per handshake carrying tick, sample_update,
//           reinitialize, level_high, host_inject and host_clicks.
//   o_out : zero or one result per request, click_count of a finished burst.
//   i_cfg : register writes, index 0 momentary_mode, index 1
//           multi_click_timeout; always ready, write only while idle.
// Timing:
//   A request accepted into the input register is processed there by the core,
//   and its result is loaded into the output register when that register can
//   load; the result handshake is made from the output register.
//   Throughput is one request per cycle while the output register can load,
//   each fired request updating the click state in the core.
// Reset:
//   Synchronous, active low. Clears both registers' valid flags and the
//   click state; momentary_mode returns to 0 and the timeout to 50.
// Stall:
//   While a result waits with o_out.ready low, the output register cannot
//   load, so the input register holds its request even if it yields no
//   result; i_in.ready drops while that register is full and cannot advance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_click_counter_unit_assert.svh"

module multi_click_counter_unit import mcc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mcc_in_if.sink    i_in,
    mcc_out_if.source o_out,
    mcc_cfg_if.sink   i_cfg
);

    t_cfg       r_cfg;
    t_in_item   in_item;
    t_in_item   stage_item;
    logic       stage_valid;
    logic       in_ready;
    logic       out_can_load;
    t_stage_ctl ctl;
    t_result    result;

    assign in_item.tick          = i_in.tick;
    assign in_item.sample_update = i_in.sample_update;
    assign in_item.reinitialize  = i_in.reinitialize;
    assign in_item.level_high    = i_in.level_high;
    assign in_item.host_inject   = i_in.host_inject;
    assign in_item.host_clicks   = i_in.host_clicks;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    assign ctl.advance = out_can_load;
    assign ctl.fire    = stage_valid && out_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.momentary_mode <= 1'b0;
            r_cfg.timeout        <= TIMEOUT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MOMENTARY_MODE: r_cfg.momentary_mode <= i_cfg.data[0];
                CFG_TIMEOUT:        r_cfg.timeout        <= i_cfg.data[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mcc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_item    (in_item),
        .i_advance (ctl.advance),
        .o_ready   (in_ready),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    mcc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_item   (stage_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    mcc_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_result      (result),
        .i_ready       (o_out.ready),
        .o_can_load    (out_can_load),
        .o_valid       (o_out.valid),
        .o_click_count (o_out.click_count)
    );

    `MCC_ASSERT_SAME(a_count_nonzero, i_clk, i_rst_n, o_out.valid, o_out.click_count != 8'd0)
    `MCC_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !o_out.valid, in_ready)
    `MCC_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, stage_valid && !out_can_load, stage_valid)
    `MCC_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, ctl.fire && result.valid, o_out.valid)

endmodule

`default_nettype wire

### design/mcc_in_reg.sv
// ----------------------------------------------------------------------------
// mcc_in_reg
// Input request register; holds while the result side is blocked.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_in_reg import mcc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    input  wire logic     i_advance,
    output logic          o_ready,
    output logic          o_valid,
    output t_in_item      o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

### design/mcc_core.sv
// ----------------------------------------------------------------------------
// mcc_core
// Click state and burst decision, one request per cycle while i_ctl.fire is set.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_core import mcc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_stage_ctl i_ctl,
    input  wire t_in_item   i_item,
    input  wire t_cfg       i_cfg,
    output t_result         o_result
);

    logic [COUNT_W-1:0] r_pending, n_pending;
    logic [TIMER_W-1:0] r_timer,   n_timer;
    logic               r_level,   n_level;
    logic               r_depart,  n_depart;
    logic               r_known,   n_known;

    always_comb begin
        logic known_in;
        logic click;
        logic check;

        n_pending = r_pending;
        n_timer   = r_timer;
        n_level   = r_level;
        n_depart  = r_depart;
        n_known   = r_known;
        known_in  = r_known && !i_item.reinitialize;
        click     = 1'b0;
        check     = 1'b0;

        if (i_item.host_inject) begin
            n_pending = i_item.host_clicks;
            n_timer   = '0;
            check     = 1'b1;
        end else begin
            if (i_item.tick && (r_timer != '0)) begin
                n_timer = r_timer - 1'b1;
            end
            n_known = known_in;
            if (i_item.sample_update) begin
                if (!known_in) begin
                    n_known = 1'b1;
                    n_level = i_item.level_high;
                end else begin
                    check = 1'b1;
                    if (i_cfg.momentary_mode) begin
                        if (i_item.level_high != r_level) begin
                            if (!r_depart) begin
                                n_depart = 1'b1;
                                click    = 1'b1;
                            end
                        end else begin
                            n_depart = 1'b0;
                        end
                    end else if (i_item.level_high != r_level) begin
                        n_level = i_item.level_high;
                        click   = 1'b1;
                    end
                end
            end
            if (click) begin
                if (r_pending != COUNT_MAX) begin
                    n_pending = r_pending + 1'b1;
                end
                n_timer = i_cfg.timeout;
            end
        end

        o_result.valid       = check && (n_pending != '0) && (n_timer == '0);
        o_result.click_count = n_pending;
        if (o_result.valid) begin
            n_pending = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_timer   <= '0;
            r_level   <= 1'b0;
            r_depart  <= 1'b0;
            r_known   <= 1'b0;
        end else if (i_ctl.fire) begin
            r_pending <= n_pending;
            r_timer   <= n_timer;
            r_level   <= n_level;
            r_depart  <= n_depart;
            r_known   <= n_known;
        end
    end

endmodule

`default_nettype wire

### design/mcc_out_reg.sv
// ----------------------------------------------------------------------------
// mcc_out_reg
// Result register; takes a new result whenever empty or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_out_reg import mcc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_stage_ctl i_ctl,
    input  wire t_result    i_result,
    input  wire logic       i_ready,
    output logic            o_can_load,
    output logic            o_valid,
    output logic [COUNT_W-1:0] o_click_count
);

    logic               r_valid;
    logic [COUNT_W-1:0] r_count;

    assign o_can_load    = !r_valid || i_ready;
    assign o_valid       = r_valid;
    assign o_click_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_ctl.fire && i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire && i_result.valid) begin
            r_count <= i_result.click_count;
        end
    end

endmodule

`default_nettype wire
